// ===== sv/jcc_pkg.sv =====
// Shared types, constants and helpers for the joystick cursor controller.
package jcc_pkg;

    localparam int DATA_W     = 10;
    localparam int COL_W      = 8;
    localparam int ROW_CODE_W = 5;
    localparam int ROW_IDX_W  = 3;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 3;

    localparam logic [ROW_IDX_W-1:0] ROW_IDX_LAST = 3'd4;

    localparam logic [COL_W-1:0] COL_RESET = 8'h80;

    localparam logic [DATA_W-1:0] REST_LOW_RESET       = 10'd500;
    localparam logic [DATA_W-1:0] REST_HIGH_RESET      = 10'd600;
    localparam logic [DATA_W-1:0] LOW_THRESHOLD_RESET  = 10'd350;
    localparam logic [DATA_W-1:0] HIGH_THRESHOLD_RESET = 10'd850;
    localparam logic [DATA_W-1:0] CENTER_VALUE_RESET   = 10'd512;
    localparam logic [DATA_W-1:0] OFF_AXIS_LIMIT_RESET = 10'd250;

    localparam logic [CFG_IDX_W-1:0] CFG_REST_LOW       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_HIGH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_VALUE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_AXIS_LIMIT = 3'd5;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE  = 3'd0,
        PH_LEFT  = 3'd1,
        PH_RIGHT = 3'd2,
        PH_UP    = 3'd3,
        PH_DOWN  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [DATA_W-1:0] rest_low;
        logic [DATA_W-1:0] rest_high;
        logic [DATA_W-1:0] low_threshold;
        logic [DATA_W-1:0] high_threshold;
        logic [DATA_W-1:0] center_value;
        logic [DATA_W-1:0] off_axis_limit;
    } t_cfg;

    typedef struct packed {
        logic [COL_W-1:0]      column_pattern;
        logic [ROW_CODE_W-1:0] row_code;
        t_phase                phase;
    } t_result;

    function automatic logic [ROW_CODE_W-1:0] row_code_of(input logic [ROW_IDX_W-1:0] idx);
        logic [ROW_CODE_W-1:0] code;
        case (idx)
            3'd0:    code = 5'h1E;
            3'd1:    code = 5'h1D;
            3'd2:    code = 5'h1B;
            3'd3:    code = 5'h17;
            3'd4:    code = 5'h0F;
            default: code = 5'h1E;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/jcc_intf.sv =====
// Handshake channel interfaces for samples, results and register writes.
interface jcc_sample_if;
    logic                           valid;
    logic                           ready;
    logic [jcc_pkg::DATA_W-1:0]     horizontal_sample;
    logic [jcc_pkg::DATA_W-1:0]     vertical_sample;

    modport source (output valid, output horizontal_sample, output vertical_sample,
                    input ready);
    modport sink   (input valid, input horizontal_sample, input vertical_sample,
                    output ready);
endinterface

interface jcc_result_if;
    logic                           valid;
    logic                           ready;
    logic [jcc_pkg::COL_W-1:0]      column_pattern;
    logic [jcc_pkg::ROW_CODE_W-1:0] row_code;
    logic [jcc_pkg::PHASE_W-1:0]    phase;

    modport source (output valid, output column_pattern, output row_code, output phase,
                    input ready);
    modport sink   (input valid, input column_pattern, input row_code, input phase,
                    output ready);
endinterface

interface jcc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [jcc_pkg::CFG_IDX_W-1:0]  index;
    logic [jcc_pkg::DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/jcc_cfg_regs.sv =====
// Threshold and band registers written through the configuration channel.
module jcc_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jcc_cfg_if.sink       i_cfg,
    output jcc_pkg::t_cfg o_cfg
);

    jcc_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rest_low       <= jcc_pkg::REST_LOW_RESET;
            r_cfg.rest_high      <= jcc_pkg::REST_HIGH_RESET;
            r_cfg.low_threshold  <= jcc_pkg::LOW_THRESHOLD_RESET;
            r_cfg.high_threshold <= jcc_pkg::HIGH_THRESHOLD_RESET;
            r_cfg.center_value   <= jcc_pkg::CENTER_VALUE_RESET;
            r_cfg.off_axis_limit <= jcc_pkg::OFF_AXIS_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                jcc_pkg::CFG_REST_LOW:       r_cfg.rest_low       <= i_cfg.data;
                jcc_pkg::CFG_REST_HIGH:      r_cfg.rest_high      <= i_cfg.data;
                jcc_pkg::CFG_LOW_THRESHOLD:  r_cfg.low_threshold  <= i_cfg.data;
                jcc_pkg::CFG_HIGH_THRESHOLD: r_cfg.high_threshold <= i_cfg.data;
                jcc_pkg::CFG_CENTER_VALUE:   r_cfg.center_value   <= i_cfg.data;
                jcc_pkg::CFG_OFF_AXIS_LIMIT: r_cfg.off_axis_limit <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/jcc_move_core.sv =====
// Direction decode and cursor state update for one sample pair.
module jcc_move_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [jcc_pkg::DATA_W-1:0] i_h,
    input  logic [jcc_pkg::DATA_W-1:0] i_v,
    input  jcc_pkg::t_cfg              i_cfg,
    output jcc_pkg::t_result           o_next
);

    jcc_pkg::t_phase                   r_phase, n_phase;
    logic [jcc_pkg::COL_W-1:0]         r_col, n_col;
    logic [jcc_pkg::ROW_IDX_W-1:0]     r_row_idx, n_row_idx;

    logic [jcc_pkg::DATA_W-1:0] w_h_dist, w_v_dist;
    logic w_h_ok, w_v_ok, w_rest;

    assign w_h_dist = (i_h > i_cfg.center_value) ? i_h - i_cfg.center_value
                                                 : i_cfg.center_value - i_h;
    assign w_v_dist = (i_v > i_cfg.center_value) ? i_v - i_cfg.center_value
                                                 : i_cfg.center_value - i_v;
    assign w_h_ok   = w_h_dist < i_cfg.off_axis_limit;
    assign w_v_ok   = w_v_dist < i_cfg.off_axis_limit;
    assign w_rest   = (i_h > i_cfg.rest_low) && (i_h < i_cfg.rest_high) &&
                      (i_v > i_cfg.rest_low) && (i_v < i_cfg.rest_high);

    always_comb begin
        n_phase   = jcc_pkg::PH_IDLE;
        n_col     = r_col;
        n_row_idx = r_row_idx;
        if (r_phase == jcc_pkg::PH_IDLE) begin
            if (w_rest) begin
                n_phase = jcc_pkg::PH_IDLE;
            end else if ((i_h < i_cfg.low_threshold) && w_v_ok) begin
                n_phase = jcc_pkg::PH_LEFT;
            end else if ((i_h > i_cfg.high_threshold) && w_v_ok) begin
                n_phase = jcc_pkg::PH_RIGHT;
            end else if ((i_v > i_cfg.high_threshold) && w_h_ok) begin
                n_phase = jcc_pkg::PH_UP;
            end else if ((i_v < i_cfg.low_threshold) && w_h_ok) begin
                n_phase = jcc_pkg::PH_DOWN;
            end
            case (n_phase)
                jcc_pkg::PH_LEFT:  n_col = {r_col[jcc_pkg::COL_W-2:0], r_col[jcc_pkg::COL_W-1]};
                jcc_pkg::PH_RIGHT: n_col = {r_col[0], r_col[jcc_pkg::COL_W-1:1]};
                jcc_pkg::PH_UP: begin
                    if (r_row_idx != '0) begin
                        n_row_idx = r_row_idx - 1'b1;
                    end
                end
                jcc_pkg::PH_DOWN: begin
                    if (r_row_idx < jcc_pkg::ROW_IDX_LAST) begin
                        n_row_idx = r_row_idx + 1'b1;
                    end else begin
                        n_row_idx = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_next.column_pattern = n_col;
    assign o_next.row_code       = jcc_pkg::row_code_of(n_row_idx);
    assign o_next.phase          = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= jcc_pkg::PH_IDLE;
            r_col     <= jcc_pkg::COL_RESET;
            r_row_idx <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_col     <= n_col;
            r_row_idx <= n_row_idx;
        end
    end

endmodule

// ===== sv/joystick_cursor_controller_top.sv =====
// Joystick cursor controller: sample register, move core and result register.
// Two register stages: the sample register, then the registered move core result.
// Throughput: one pair per cycle unless o_result stalls; cursor state steps per pair.
// Reset (synchronous, active low) empties both stages, sets idle phase,
// column 0x80, row 0, and loads the default band and threshold registers.
module joystick_cursor_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jcc_sample_if.sink  i_sample,
    jcc_result_if.source o_result,
    jcc_cfg_if.sink     i_cfg
);

    jcc_pkg::t_cfg    w_cfg;
    jcc_pkg::t_result w_next;

    logic                       r_in_valid;
    logic [jcc_pkg::DATA_W-1:0] r_h, r_v;
    logic                       r_out_valid;
    jcc_pkg::t_result           r_out;

    logic w_out_free, w_advance;

    assign w_out_free     = !r_out_valid || o_result.ready;
    assign w_advance      = r_in_valid && w_out_free;
    assign i_sample.ready = !r_in_valid || w_advance;

    jcc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    jcc_move_core u_move_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_h     (r_h),
        .i_v     (r_v),
        .i_cfg   (w_cfg),
        .o_next  (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_sample.ready) begin
                r_in_valid <= i_sample.valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_h <= i_sample.horizontal_sample;
            r_v <= i_sample.vertical_sample;
        end
        if (w_advance) begin
            r_out <= w_next;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.column_pattern = r_out.column_pattern;
    assign o_result.row_code       = r_out.row_code;
    assign o_result.phase          = r_out.phase;

endmodule
